/* rtl/core/dnsenc_pkg.sv */
// Shared constants and types for the DNS name to wire-format encoder.
`default_nettype none

package dnsenc_pkg;

  // Default longest label that is kept, in bytes
  localparam int unsigned DEF_MAX_LABEL = 63;

  // Character codes
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  // Data byte width and tuser width on the stream ports
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OUT_USER_W = 3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_BYTES
  } enc_state_e;

  // Per-result flags carried in the output tuser
  typedef struct packed {
    logic label_overflow;
    logic name_done;
    logic is_length;
  } out_flags_t;

endpackage

`default_nettype wire

/* rtl/core/dnsenc_label_buf.sv */
// Label byte buffer: one write port, one read port with registered data.
`default_nettype none

module dnsenc_label_buf
  import dnsenc_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_MAX_LABEL,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [BYTE_W-1:0] wr_data_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output logic      [BYTE_W-1:0] rd_data_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/dns_name_to_wire_encoder_unit.sv */
// Top level: collects characters of a dotted name and replays each label as length + bytes.
`default_nettype none

// Channel   Dir  tdata            tuser                                tlast
// s_axis    in   char_in[7:0]     -                                    final_char
// m_axis    out  out_byte[7:0]    is_length, name_done, label_overflow run_last
//
// A character is taken while the sequencer is idle. A '.' or the final
// character with a non-empty label starts a replay: the length byte, then
// each label byte read from the buffer in turn, each one held back by any
// output stall. No request is taken during a replay. Reset clears the label
// count and the output valid flag; the buffer contents are never cleared.

module dns_name_to_wire_encoder_unit
  import dnsenc_pkg::*;
#(
  parameter int unsigned MAX_LABEL = DEF_MAX_LABEL
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] char_in
  input  wire logic                  s_axis_tlast,   // final_char
  // output stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [BYTE_W-1:0]     m_axis_tdata,   // [7:0] out_byte
  output logic      [OUT_USER_W-1:0] m_axis_tuser,   // [0] is_length, [1] name_done,
                                                     // [2] label_overflow
  output logic                       m_axis_tlast    // run_last
);

  localparam int unsigned AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int unsigned CW = $clog2(MAX_LABEL + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_LABEL);

  enc_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] len_q, len_d;
  logic          len_ovf_q, len_ovf_d;
  logic          fin_q, fin_d;
  logic [AW-1:0] idx_q, idx_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  out_flags_t        out_flags_q, out_flags_d;
  logic              out_last_q, out_last_d;

  logic              in_fire;
  logic [BYTE_W-1:0] char_fold;
  logic              is_dot;
  logic              do_store;
  logic              out_free;
  logic              last_byte;
  logic [CW-1:0]     cnt_after;
  logic [BYTE_W-1:0] rd_data;

  // Case folding and write decision for the incoming character
  always_comb begin
    char_fold = s_axis_tdata;
    if (s_axis_tdata >= CHAR_UPPER_A && s_axis_tdata <= CHAR_UPPER_Z) begin
      char_fold = s_axis_tdata + CASE_OFFSET;
    end
  end

  assign is_dot    = (char_fold == CHAR_DOT);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign do_store  = in_fire && !is_dot && (count_q < MaxCnt);
  assign cnt_after = do_store ? (count_q + CW'(1)) : count_q;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign last_byte = ((CW'(idx_q) + CW'(1)) == len_q);

  dnsenc_label_buf #(
    .DEPTH(MAX_LABEL),
    .AW   (AW)
  ) u_buf (
    .clk_i    (clk_i),
    .wr_en_i  (do_store),
    .wr_addr_i(count_q[AW-1:0]),
    .wr_data_i(char_fold),
    .rd_addr_i(idx_d),
    .rd_data_o(rd_data)
  );

  // Sequencer: next state and output register loads
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    len_d       = len_q;
    len_ovf_d   = len_ovf_q;
    fin_d       = fin_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_byte_d  = out_byte_q;
    out_flags_d = out_flags_q;
    out_last_d  = out_last_q;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        idx_d = '0;
        if (in_fire) begin
          count_d = cnt_after;
          if (!is_dot && count_q >= MaxCnt) begin
            ovf_d = 1'b1;
          end
          if (is_dot || s_axis_tlast) begin
            // flush: latch the label and clear the collector
            len_d     = cnt_after;
            len_ovf_d = ovf_q || (!is_dot && count_q >= MaxCnt);
            fin_d     = s_axis_tlast;
            count_d   = '0;
            ovf_d     = 1'b0;
            if (cnt_after != '0) begin
              state_d = ST_LEN;
            end
          end
        end
      end

      ST_LEN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = BYTE_W'(len_q);
          out_flags_d = '{label_overflow: len_ovf_q, name_done: 1'b0, is_length: 1'b1};
          out_last_d  = 1'b0;
          state_d     = ST_BYTES;
        end
      end

      ST_BYTES: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = rd_data;
          out_flags_d = '{label_overflow: len_ovf_q,
                          name_done:      last_byte && fin_q,
                          is_length:      1'b0};
          out_last_d  = last_byte;
          if (last_byte) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    len_q       <= len_d;
    len_ovf_q   <= len_ovf_d;
    fin_q       <= fin_d;
    out_byte_q  <= out_byte_d;
    out_flags_q <= out_flags_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_flags_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
